// ===== hdl/frm_pkg.sv =====
// Shared types, constants and helpers for the frame rate meter.
// Used by frm_divider and frame_rate_meter_with_fallback; depends on nothing.

package frm_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned RATE_W      = 8;
   localparam int unsigned THR_W       = 4;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 8;
   localparam int unsigned COUNT_W     = 5;   // iteration counter of the divider
   localparam int unsigned MS_W        = 23;  // whole ms of a 32-bit us span fit in 23 bits
   localparam int unsigned PROD_W      = 64;

   // floor(x / 1000) == (x * MS_MAGIC) >> MS_SHIFT for any 32-bit x
   localparam logic [WORD_W-1:0] MS_MAGIC = 32'h1062_4DD3;
   localparam int unsigned       MS_SHIFT = 38;

   localparam logic [RATE_W-1:0] RATE_LIMIT_RESET      = 8'd255;
   localparam logic [THR_W-1:0]  STALL_THRESHOLD_RESET = 4'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_LIMIT      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALL_THRESHOLD = 2'd1;

   typedef struct packed {
      logic [WORD_W-1:0] sample_time;
      logic [WORD_W-1:0] previous_time;
      logic [WORD_W-1:0] flip_count;
      logic [WORD_W-1:0] submit_count;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0] frames_per_second;
      logic              fallback_active;
      logic              flips_seen;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_SEND
   } state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_SCALE,
      DIV_RUN
   } div_state_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] delta;
      logic [WORD_W-1:0] elapsed;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic              div_zero;
      logic [WORD_W-1:0] quotient;
   } div_sts_type;

   // x * 1000 modulo 2^32, as 1024 - 32 + 8
   function automatic logic [WORD_W-1:0] mul1000(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] s10;
      logic [WORD_W-1:0] s5;
      logic [WORD_W-1:0] s3;
      s10 = x << 10;
      s5  = x << 5;
      s3  = x << 3;
      return s10 - s5 + s3;
   endfunction

endpackage

// ===== hdl/frm_divider.sv =====
// Shared arithmetic unit: scales the elapsed time to whole ms by a reciprocal
// multiply, then divides delta*1000 by it one quotient bit per cycle. Uses frm_pkg.

module frm_divider (
   input  logic                clock,
   input  logic                reset,
   input  frm_pkg::div_cmd_type cmd,
   output frm_pkg::div_sts_type sts
);

   frm_pkg::div_state_type             state_ff, state_in;
   logic [frm_pkg::WORD_W-1:0]         num_ff, num_in;
   logic [frm_pkg::WORD_W-1:0]         elapsed_ff, elapsed_in;
   logic [frm_pkg::MS_W-1:0]           ms_ff, ms_in;
   logic [frm_pkg::MS_W-1:0]           rem_ff, rem_in;
   logic [frm_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic                               done_ff, done_in;

   logic [frm_pkg::PROD_W-1:0]         product;
   logic [frm_pkg::MS_W:0]             trial;
   logic [frm_pkg::MS_W:0]             diff;
   logic                               qbit;

   assign product = {{(frm_pkg::PROD_W-frm_pkg::WORD_W){1'b0}}, elapsed_ff}
                  * {{(frm_pkg::PROD_W-frm_pkg::WORD_W){1'b0}}, frm_pkg::MS_MAGIC};
   assign trial   = {rem_ff, num_ff[frm_pkg::WORD_W-1]};
   assign diff    = trial - {1'b0, ms_ff};
   assign qbit    = (trial >= {1'b0, ms_ff});

   always_comb begin
      state_in   = state_ff;
      num_in     = num_ff;
      elapsed_in = elapsed_ff;
      ms_in      = ms_ff;
      rem_in     = rem_ff;
      count_in   = count_ff;
      done_in    = 1'b0;
      unique case (state_ff)
         frm_pkg::DIV_IDLE: begin
            if (cmd.start) begin
               num_in     = cmd.delta;
               elapsed_in = cmd.elapsed;
               state_in   = frm_pkg::DIV_SCALE;
            end
         end
         frm_pkg::DIV_SCALE: begin
            num_in   = frm_pkg::mul1000(num_ff);
            ms_in    = product[frm_pkg::MS_SHIFT +: frm_pkg::MS_W];
            rem_in   = '0;
            count_in = '0;
            state_in = frm_pkg::DIV_RUN;
         end
         frm_pkg::DIV_RUN: begin
            // restoring step: quotient bits shift in as dividend bits shift out
            num_in   = {num_ff[frm_pkg::WORD_W-2:0], qbit};
            rem_in   = qbit ? diff[frm_pkg::MS_W-1:0] : trial[frm_pkg::MS_W-1:0];
            count_in = count_ff + 1'b1;
            if (count_ff == frm_pkg::COUNT_W'(frm_pkg::WORD_W - 1)) begin
               done_in  = 1'b1;
               state_in = frm_pkg::DIV_IDLE;
            end
         end
         default: begin
            state_in = frm_pkg::DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frm_pkg::DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      num_ff     <= num_in;
      elapsed_ff <= elapsed_in;
      ms_ff      <= ms_in;
      rem_ff     <= rem_in;
      count_ff   <= count_in;
   end

   assign sts.done     = done_ff;
   assign sts.div_zero = (ms_ff == '0);
   assign sts.quotient = num_ff;

endmodule

// ===== hdl/frame_rate_meter_with_fallback.sv =====
// Top level of the frame rate meter with fallback counter.
// Depends on frm_pkg and frm_divider.
//
// Usage:
//   req channel (valid/ready) carries one sample: timestamp, previous
//   timestamp, flip counter and submission counter. rsp channel (valid/ready)
//   returns exactly one result per request: held rate, fallback flag and
//   whether the flip counter moved.
//   csr port: csr_write_en with csr_index 0 (rate limit) or 1 (stall
//   threshold); other indexes are dropped. Write only while the block is idle.
// Flow:
//   One request at a time. A sample with a usable time span moves from accept
//   to rsp_valid in order: the accepting edge latches it, then one reciprocal
//   multiply for the whole ms count, the bit-serial steps of the shared
//   restoring divider, a clamp step and the load of the output register.
//   Other samples go straight to that load. req_ready returns on the edge that
//   loads the output register, so a new request waits until the last is loaded.
// Reset: rate limit 255, threshold 3, all meter state cleared, no result held.
// Stall: a result waits in the output register while rsp_ready is low; a
//   finished next result waits in the sequencer until the register frees up.

module frame_rate_meter_with_fallback (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  frm_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output frm_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_write_en,
   input  logic [frm_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [frm_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   frm_pkg::state_type                 state_ff, state_in;
   logic [frm_pkg::RATE_W-1:0]         rate_limit_ff, rate_limit_in;
   logic [frm_pkg::THR_W-1:0]          threshold_ff, threshold_in;
   logic [frm_pkg::RATE_W-1:0]         held_rate_ff, held_rate_in;
   logic [frm_pkg::WORD_W-1:0]         prior_flip_ff, prior_flip_in;
   logic [frm_pkg::WORD_W-1:0]         prior_submit_ff, prior_submit_in;
   logic [frm_pkg::THR_W-1:0]          idle_count_ff, idle_count_in;
   logic                               fallback_ff, fallback_in;
   logic                               flips_seen_ff, flips_seen_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   frm_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   frm_pkg::div_cmd_type               div_cmd;
   frm_pkg::div_sts_type               div_sts;

   logic                               accept;
   logic                               sample_ok;
   logic [frm_pkg::WORD_W-1:0]         flip_delta;
   logic [frm_pkg::WORD_W-1:0]         submit_delta;
   logic                               out_free;
   logic [frm_pkg::THR_W-1:0]          count_next;
   logic                               fallback_next;

   assign req_ready    = (state_ff == frm_pkg::ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign sample_ok    = (req_data.previous_time != '0)
                      && (req_data.previous_time < req_data.sample_time);
   assign flip_delta   = req_data.flip_count - prior_flip_ff;
   assign submit_delta = req_data.submit_count - prior_submit_ff;
   assign out_free     = !rsp_valid_ff || rsp_ready;

   // stall counting and fallback decision for a usable sample
   always_comb begin
      count_next    = idle_count_ff;
      fallback_next = fallback_ff;
      if (flip_delta == '0) begin
         if (idle_count_ff < threshold_ff) begin
            count_next = idle_count_ff + 1'b1;
         end
      end else begin
         count_next    = '0;
         fallback_next = 1'b0;
      end
      if (count_next >= threshold_ff) begin
         fallback_next = 1'b1;
      end
   end

   assign div_cmd.start   = accept && sample_ok;
   assign div_cmd.delta   = fallback_next ? submit_delta : flip_delta;
   assign div_cmd.elapsed = req_data.sample_time - req_data.previous_time;

   frm_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   always_comb begin
      state_in        = state_ff;
      rate_limit_in   = rate_limit_ff;
      threshold_in    = threshold_ff;
      held_rate_in    = held_rate_ff;
      prior_flip_in   = prior_flip_ff;
      prior_submit_in = prior_submit_ff;
      idle_count_in   = idle_count_ff;
      fallback_in     = fallback_ff;
      flips_seen_in   = flips_seen_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            frm_pkg::CSR_RATE_LIMIT:      rate_limit_in = csr_wdata;
            frm_pkg::CSR_STALL_THRESHOLD: threshold_in  = csr_wdata[frm_pkg::THR_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         frm_pkg::ST_IDLE: begin
            if (accept) begin
               prior_flip_in   = req_data.flip_count;
               prior_submit_in = req_data.submit_count;
               flips_seen_in   = (flip_delta != '0);
               if (sample_ok) begin
                  idle_count_in = count_next;
                  fallback_in   = fallback_next;
                  state_in      = frm_pkg::ST_CALC;
               end else begin
                  state_in = frm_pkg::ST_SEND;
               end
            end
         end
         frm_pkg::ST_CALC: begin
            if (div_sts.done) begin
               priority if (div_sts.div_zero) begin
                  held_rate_in = '0;
               end else if (div_sts.quotient >
                            {{(frm_pkg::WORD_W-frm_pkg::RATE_W){1'b0}}, rate_limit_ff}) begin
                  held_rate_in = rate_limit_ff;
               end else begin
                  held_rate_in = div_sts.quotient[frm_pkg::RATE_W-1:0];
               end
               state_in = frm_pkg::ST_SEND;
            end
         end
         frm_pkg::ST_SEND: begin
            if (out_free) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.frames_per_second = held_rate_ff;
               rsp_data_in.fallback_active   = fallback_ff;
               rsp_data_in.flips_seen        = flips_seen_ff;
               state_in                      = frm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= frm_pkg::ST_IDLE;
         rate_limit_ff   <= frm_pkg::RATE_LIMIT_RESET;
         threshold_ff    <= frm_pkg::STALL_THRESHOLD_RESET;
         held_rate_ff    <= '0;
         prior_flip_ff   <= '0;
         prior_submit_ff <= '0;
         idle_count_ff   <= '0;
         fallback_ff     <= 1'b0;
         flips_seen_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rate_limit_ff   <= rate_limit_in;
         threshold_ff    <= threshold_in;
         held_rate_ff    <= held_rate_in;
         prior_flip_ff   <= prior_flip_in;
         prior_submit_ff <= prior_submit_in;
         idle_count_ff   <= idle_count_in;
         fallback_ff     <= fallback_in;
         flips_seen_ff   <= flips_seen_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // divider completion only while the sequencer waits on it
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == frm_pkg::ST_CALC))
      else $error("divider finished outside of calc state");

   // a sample without a usable time span skips the divider
   a_invalid_skips_div: assert property (@(posedge clock) disable iff (reset)
      (accept && !sample_ok) |=> (state_ff == frm_pkg::ST_SEND))
      else $error("unusable sample did not go straight to send");

   // a result leaving the sequencer lands in the output register
   a_send_loads_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == frm_pkg::ST_SEND && out_free) |=> (rsp_valid && req_ready))
      else $error("result not loaded into output register");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for frame_rate_meter_with_fallback: random and directed samples,
// a built-in rate predictor and a result scoreboard, with idling on both channels.
// Depends on frm_pkg and the meter RTL.

module tb_top;

   localparam logic [frm_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [frm_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam int unsigned MAX_GAP      = 12;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned STUCK_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned PHASE_ITEMS  = 210;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   frm_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   frm_pkg::rsp_type                rsp_data;
   logic                            csr_write_en = 1'b0;
   logic [frm_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [frm_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   frm_pkg::req_type pending_requests[$];
   frm_pkg::rsp_type expected_results[$];
   int unsigned      requests_issued = 0;
   int unsigned      results_seen = 0;
   int unsigned      error_count = 0;
   int unsigned      stuck_cycles = 0;
   bit               no_gaps = 1'b0;

   // predictor state and register copies
   logic [frm_pkg::RATE_W-1:0] est_rate = '0;
   logic [frm_pkg::WORD_W-1:0] est_prior_flips = '0;
   logic [frm_pkg::WORD_W-1:0] est_prior_subs = '0;
   logic [frm_pkg::THR_W-1:0]  est_idle_run = '0;
   logic                       est_fallback = 1'b0;
   logic [frm_pkg::RATE_W-1:0] cfg_rate_limit = frm_pkg::RATE_LIMIT_RESET;
   logic [frm_pkg::THR_W-1:0]  cfg_stall_threshold = frm_pkg::STALL_THRESHOLD_RESET;

   // sample generator scene
   logic [frm_pkg::WORD_W-1:0] scene_time = 32'h0001_0000;
   logic [frm_pkg::WORD_W-1:0] scene_flips = '0;
   logic [frm_pkg::WORD_W-1:0] scene_subs = '0;
   int unsigned                flipless_left = 0;

   frame_rate_meter_with_fallback dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic frm_pkg::rsp_type meter_predict(input frm_pkg::req_type s);
      logic [frm_pkg::WORD_W-1:0] flip_delta;
      logic [frm_pkg::WORD_W-1:0] sub_delta;
      logic [frm_pkg::WORD_W-1:0] whole_ms;
      logic [frm_pkg::WORD_W-1:0] scaled;
      logic [frm_pkg::WORD_W-1:0] quot;
      frm_pkg::rsp_type           r;
      flip_delta = s.flip_count - est_prior_flips;
      sub_delta  = s.submit_count - est_prior_subs;
      if (s.previous_time != '0 && s.previous_time < s.sample_time) begin
         if (flip_delta == '0) begin
            if (est_idle_run < cfg_stall_threshold)
               est_idle_run = est_idle_run + 1'b1;
         end else begin
            est_idle_run = '0;
            est_fallback = 1'b0;
         end
         if (est_idle_run >= cfg_stall_threshold)
            est_fallback = 1'b1;
         whole_ms = (s.sample_time - s.previous_time) / 32'd1000;
         if (whole_ms == '0) begin
            est_rate = '0;
         end else begin
            // product wraps at 32 bits before the divide
            scaled = (est_fallback ? sub_delta : flip_delta) * 32'd1000;
            quot   = scaled / whole_ms;
            est_rate = (quot > cfg_rate_limit) ? cfg_rate_limit
                                               : quot[frm_pkg::RATE_W-1:0];
         end
      end
      est_prior_flips = s.flip_count;
      est_prior_subs  = s.submit_count;
      r.frames_per_second = est_rate;
      r.fallback_active   = est_fallback;
      r.flips_seen        = (flip_delta != '0);
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin : request_driver
      int unsigned send_wait;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid)
            expected_results.push_back(meter_predict(req_data));
         if (send_wait > 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_data  <= pending_requests.pop_front();
            req_valid <= 1'b1;
            send_wait = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor and scoreboard
   always @(posedge clock) begin : result_monitor
      int unsigned      recv_wait;
      frm_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: fps %0d fallback %0d flips_seen %0d",
                      rsp_data.frames_per_second, rsp_data.fallback_active,
                      rsp_data.flips_seen);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.frames_per_second !== want.frames_per_second) begin
                  $error("frames_per_second: expected %0d, actual %0d",
                         want.frames_per_second, rsp_data.frames_per_second);
                  error_count++;
               end
               if (rsp_data.fallback_active !== want.fallback_active) begin
                  $error("fallback_active: expected %0d, actual %0d",
                         want.fallback_active, rsp_data.fallback_active);
                  error_count++;
               end
               if (rsp_data.flips_seen !== want.flips_seen) begin
                  $error("flips_seen: expected %0d, actual %0d",
                         want.flips_seen, rsp_data.flips_seen);
                  error_count++;
               end
            end
            results_seen++;
            recv_wait = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            // long back-pressure so the meter fills and stalls its request side
            if (results_seen % 600 == 250)
               recv_wait = HOLD_CYCLES;
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic queue_sample(input logic [frm_pkg::WORD_W-1:0] now,
                               input logic [frm_pkg::WORD_W-1:0] prev,
                               input logic [frm_pkg::WORD_W-1:0] flips,
                               input logic [frm_pkg::WORD_W-1:0] subs);
      frm_pkg::req_type s;
      s.sample_time   = now;
      s.previous_time = prev;
      s.flip_count    = flips;
      s.submit_count  = subs;
      pending_requests.push_back(s);
      requests_issued++;
   endtask

   task automatic queue_random_sample();
      logic [frm_pkg::WORD_W-1:0] elapsed;
      logic [frm_pkg::WORD_W-1:0] prev;
      int unsigned                pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         // well-formed chain: previous time is the last sample time
         pick = $urandom_range(0, 99);
         if (pick < 70)
            elapsed = $urandom_range(200000, 2000000);
         else if (pick < 80)
            elapsed = $urandom_range(0, 999);
         else if (pick < 90)
            elapsed = $urandom_range(1000, 5000);
         else
            elapsed = $urandom;
         if (flipless_left > 0)
            flipless_left--;
         else if ($urandom_range(0, 9) < 3)
            flipless_left = $urandom_range(2, 20);
         if (flipless_left == 0)
            scene_flips += ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 300);
         scene_subs += ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 300);
         prev = scene_time;
         scene_time = scene_time + elapsed;
         queue_sample(scene_time, prev, scene_flips, scene_subs);
      end else if (pick < 85) begin
         scene_flips += $urandom_range(0, 3);
         queue_sample($urandom, '0, scene_flips, scene_subs);
      end else begin
         queue_sample($urandom, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic write_reg(input logic [frm_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [frm_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      if (idx == frm_pkg::CSR_RATE_LIMIT)
         cfg_rate_limit = value;
      else if (idx == frm_pkg::CSR_STALL_THRESHOLD)
         cfg_stall_threshold = value[frm_pkg::THR_W-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (results_seen != requests_issued)
         @(negedge clock);
   endtask

   initial begin
      logic [frm_pkg::RATE_W-1:0] phase_limit;
      logic [frm_pkg::THR_W-1:0]  phase_thr;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults: rate limit 255, threshold 3
      queue_sample(32'd0, 32'd0, 32'd0, 32'd0);
      queue_sample(32'd1000, 32'd1000, 32'd5, 32'd0);
      queue_sample(32'd1000, 32'd5000, 32'd5, 32'd0);
      queue_sample(32'd1000, 32'd1, 32'd5, 32'd0);
      queue_sample(32'd2000000, 32'd1000000, 32'd65, 32'd10);
      queue_sample(32'd3000000, 32'd2000000, 32'd65, 32'd40);
      queue_sample(32'd4000000, 32'd3000000, 32'd65, 32'd70);
      queue_sample(32'd5000000, 32'd4000000, 32'd65, 32'd100);
      queue_sample(32'd6000000, 32'd5000000, 32'd65, 32'd130);
      queue_sample(32'd7000000, 32'd6000000, 32'd66, 32'd140);
      // delta * 1000 wrapping: huge, then tiny after the wrap
      queue_sample(32'd7001000, 32'd7000000, 32'h0100_0042, 32'd140);
      queue_sample(32'd7020000, 32'd7010000, 32'h0100_0042 + 32'd4294968, 32'd140);
      queue_sample(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_sample(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      wait_idle();

      // build a long flip-less run, then drop the threshold under it
      write_reg(frm_pkg::CSR_STALL_THRESHOLD, 8'd15);
      write_reg(frm_pkg::CSR_RATE_LIMIT, 8'd100);
      for (int i = 0; i < 8; i++)
         queue_sample((i + 2) * 1000000, (i + 1) * 1000000, 32'd0, i * 150);
      wait_idle();
      write_reg(frm_pkg::CSR_STALL_THRESHOLD, 8'd2);
      queue_sample(32'd11000000, 32'd10000000, 32'd0, 32'd1300);
      wait_idle();
      write_reg(frm_pkg::CSR_STALL_THRESHOLD, 8'd0);
      write_reg(frm_pkg::CSR_RATE_LIMIT, 8'd0);
      queue_sample(32'd12000000, 32'd11000000, 32'd9, 32'd1400);
      queue_sample(32'd13000000, 32'd12000000, 32'd9, 32'd1500);
      wait_idle();
      // writes past the register list must be dropped
      write_reg(CSR_SPARE_A, 8'hFF);
      write_reg(CSR_SPARE_B, 8'hFF);
      queue_sample(32'd14000000, 32'd13000000, 32'd90, 32'd1600);
      queue_sample(32'd15000000, 32'd14000000, 32'd90, 32'd1700);
      wait_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin phase_limit = 8'd255; phase_thr = 4'd3; end
            1: begin phase_limit = 8'd1; phase_thr = 4'd15; end
            2: begin phase_limit = 8'd0; phase_thr = 4'd0; end
            3: begin phase_limit = 8'd255; phase_thr = 4'd1; end
            5: begin phase_limit = 8'd128; phase_thr = 4'd15; end
            default: begin
               phase_limit = frm_pkg::RATE_W'($urandom_range(0, 255));
               phase_thr   = frm_pkg::THR_W'($urandom_range(0, 15));
            end
         endcase
         no_gaps = (phase % 4 == 2);
         write_reg(frm_pkg::CSR_RATE_LIMIT, phase_limit);
         write_reg(frm_pkg::CSR_STALL_THRESHOLD,
                   {{(frm_pkg::CSR_DATA_W-frm_pkg::THR_W){1'b0}}, phase_thr});
         if (phase % 3 == 1)
            write_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                      frm_pkg::CSR_DATA_W'($urandom));
         for (int k = 0; k < PHASE_ITEMS; k++)
            queue_random_sample();
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
